// ----- design/nv12dt_pkg.sv -----
// ----------------------------------------------------------------------------
// nv12dt_pkg
// shared types and constants for the nv12 64x32 tile detile address block
// ----------------------------------------------------------------------------
`default_nettype none

package nv12dt_pkg;

    // saturation limits of the configuration registers
    localparam int MAX_WIDTH     = 4096;
    localparam int MAX_HEIGHT    = 4096;
    localparam int MAX_LINE_SIZE = 8192;

    // tile geometry
    localparam int TILE_W      = 64;
    localparam int TILE_H      = 32;
    localparam int TILE_SHIFT  = 11;   // 2048-byte tiles
    localparam int GROUP_SHIFT = 13;   // luma plane rounded to 8192 bytes

    // field and register widths
    localparam int WIDTH_W = 13;
    localparam int LINE_W  = 14;
    localparam int ROW_W   = 12;
    localparam int COL_W   = 12;
    localparam int OFF_W   = 25;
    localparam int CFG_W   = 14;
    localparam int IDX_W   = 2;

    // tile coordinate and tile count widths
    localparam int TX_W  = COL_W - $clog2(TILE_W);            // tile column
    localparam int TY_W  = ROW_W - $clog2(TILE_H);            // tile row
    localparam int TWC_W = $clog2(MAX_WIDTH / TILE_W) + 1;    // tiles per row
    localparam int THC_W = $clog2(MAX_HEIGHT / TILE_H) + 1;   // luma tile rows
    localparam int POS_W = TWC_W + TY_W;                      // tile index

    // register indexes
    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_LINE_SIZE    = 2'd2;

    // reset values
    localparam logic [WIDTH_W-1:0] RST_FRAME_WIDTH  = 13'd1920;
    localparam logic [WIDTH_W-1:0] RST_FRAME_HEIGHT = 13'd1080;
    localparam logic [LINE_W-1:0]  RST_LINE_SIZE    = 14'd1920;

    // plane codes
    localparam logic PLANE_LUMA   = 1'b0;
    localparam logic PLANE_CHROMA = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_req;

    typedef struct packed {
        logic [OFF_W-1:0] src_offset;
        logic [OFF_W-1:0] dst_offset;
        logic             in_frame;
    } t_res;

    // frame geometry derived from the registers
    typedef struct packed {
        logic [WIDTH_W-1:0] width;
        logic [WIDTH_W-1:0] luma_rows;
        logic [ROW_W-1:0]   chroma_rows;
        logic [LINE_W-1:0]  line;
        logic [TWC_W-1:0]   tw_even;
        logic [TY_W-1:0]    luma_last_ty;
        logic               luma_odd;
        logic [TY_W-1:0]    chroma_last_ty;
        logic               chroma_odd;
        logic [OFF_W-1:0]   chroma_base;
    } t_geom;

endpackage

`default_nettype wire

// ----- design/nv12dt_cfg.sv -----
// ----------------------------------------------------------------------------
// nv12dt_cfg
// configuration registers and registered frame geometry
// ----------------------------------------------------------------------------
`default_nettype none

module nv12dt_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [nv12dt_pkg::IDX_W-1:0]  i_cfg_idx,
    input  wire logic [nv12dt_pkg::CFG_W-1:0]  i_cfg_data,
    output      nv12dt_pkg::t_geom             o_geom
);

    logic [nv12dt_pkg::WIDTH_W-1:0] r_width;
    logic [nv12dt_pkg::WIDTH_W-1:0] r_height;
    logic [nv12dt_pkg::LINE_W-1:0]  r_line;
    nv12dt_pkg::t_geom              r_geom;
    nv12dt_pkg::t_geom              n_geom;

    logic [nv12dt_pkg::WIDTH_W-1:0] w_sat;
    logic [nv12dt_pkg::WIDTH_W-1:0] h_sat;
    logic [nv12dt_pkg::WIDTH_W-1:0] w_m1;
    logic [nv12dt_pkg::WIDTH_W-1:0] h_m1;
    logic [nv12dt_pkg::ROW_W-1:0]   hc;
    logic [nv12dt_pkg::ROW_W-1:0]   hc_m1;
    logic [nv12dt_pkg::TWC_W-1:0]   tiles_w;
    logic [nv12dt_pkg::THC_W-1:0]   th_luma;
    logic [nv12dt_pkg::TWC_W-1:0]   th_chroma;
    logic [nv12dt_pkg::POS_W-1:0]   luma_tiles;
    logic [nv12dt_pkg::POS_W-1:0]   luma_tiles_p3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= nv12dt_pkg::RST_FRAME_WIDTH;
            r_height <= nv12dt_pkg::RST_FRAME_HEIGHT;
            r_line   <= nv12dt_pkg::RST_LINE_SIZE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                nv12dt_pkg::REG_FRAME_WIDTH:  r_width  <= i_cfg_data[nv12dt_pkg::WIDTH_W-1:0];
                nv12dt_pkg::REG_FRAME_HEIGHT: r_height <= i_cfg_data[nv12dt_pkg::WIDTH_W-1:0];
                nv12dt_pkg::REG_LINE_SIZE:    r_line   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_sat = (r_width > nv12dt_pkg::WIDTH_W'(nv12dt_pkg::MAX_WIDTH))
              ? nv12dt_pkg::WIDTH_W'(nv12dt_pkg::MAX_WIDTH) : r_width;
        h_sat = (r_height > nv12dt_pkg::WIDTH_W'(nv12dt_pkg::MAX_HEIGHT))
              ? nv12dt_pkg::WIDTH_W'(nv12dt_pkg::MAX_HEIGHT) : r_height;
        w_m1  = w_sat - 1'b1;
        h_m1  = h_sat - 1'b1;
        hc    = h_sat[nv12dt_pkg::WIDTH_W-1:1];
        hc_m1 = hc - 1'b1;

        // tile counts; only meaningful for a nonzero frame
        tiles_w   = nv12dt_pkg::TWC_W'(w_m1 >> $clog2(nv12dt_pkg::TILE_W)) + 1'b1;
        th_luma   = nv12dt_pkg::THC_W'(h_m1 >> $clog2(nv12dt_pkg::TILE_H)) + 1'b1;
        th_chroma = nv12dt_pkg::TWC_W'(hc_m1 >> $clog2(nv12dt_pkg::TILE_H)) + 1'b1;

        n_geom.width       = w_sat;
        n_geom.luma_rows   = {h_sat[nv12dt_pkg::WIDTH_W-1:1], 1'b0};
        n_geom.chroma_rows = hc;
        n_geom.line        = (r_line > nv12dt_pkg::LINE_W'(nv12dt_pkg::MAX_LINE_SIZE))
                           ? nv12dt_pkg::LINE_W'(nv12dt_pkg::MAX_LINE_SIZE) : r_line;
        n_geom.tw_even     = (tiles_w + 1'b1) & ~nv12dt_pkg::TWC_W'(1);

        n_geom.luma_last_ty   = nv12dt_pkg::TY_W'(th_luma - 1'b1);
        n_geom.luma_odd       = th_luma[0];
        n_geom.chroma_last_ty = nv12dt_pkg::TY_W'(th_chroma - 1'b1);
        n_geom.chroma_odd     = th_chroma[0];

        // luma size in tiles, rounded up to groups of four tiles
        luma_tiles    = nv12dt_pkg::POS_W'(n_geom.tw_even * th_luma);
        luma_tiles_p3 = luma_tiles + nv12dt_pkg::POS_W'(3);
        n_geom.chroma_base = nv12dt_pkg::OFF_W'({luma_tiles_p3[nv12dt_pkg::POS_W-1:2],
                                                 {nv12dt_pkg::GROUP_SHIFT{1'b0}}});
    end

    // geometry is recomputed every cycle and registered, so it is ready in the cycle after a write lands
    always_ff @(posedge i_clk) begin
        r_geom <= n_geom;
    end

    assign o_geom = r_geom;

endmodule

`default_nettype wire

// ----- design/nv12dt_map.sv -----
// ----------------------------------------------------------------------------
// nv12dt_map
// address mapping of one destination byte position
// ----------------------------------------------------------------------------
`default_nettype none

module nv12dt_map (
    input  wire nv12dt_pkg::t_req   i_req,
    input  wire nv12dt_pkg::t_geom  i_geom,
    output      nv12dt_pkg::t_res   o_res
);

    logic [nv12dt_pkg::TX_W-1:0]  tx;
    logic [nv12dt_pkg::TY_W-1:0]  ty;
    logic [nv12dt_pkg::TY_W-1:0]  last_ty;
    logic                         odd_rows;
    logic                         in_area;
    logic [nv12dt_pkg::POS_W-1:0] pair_base;
    logic [nv12dt_pkg::TWC_W:0]   zz_adj;
    logic [nv12dt_pkg::TWC_W:0]   tx_p2;
    logic [nv12dt_pkg::POS_W-1:0] pos;
    logic [nv12dt_pkg::OFF_W-1:0] src;
    logic [nv12dt_pkg::OFF_W:0]   dst;

    always_comb begin
        tx = i_req.col[nv12dt_pkg::COL_W-1 -: nv12dt_pkg::TX_W];
        // chroma half tiles span 16 rows, so row / 32 is the tile row in both planes
        ty = i_req.row[nv12dt_pkg::ROW_W-1 -: nv12dt_pkg::TY_W];

        if (i_req.req_type == nv12dt_pkg::PLANE_CHROMA) begin
            in_area  = ({1'b0, i_req.col} < i_geom.width) && (i_req.row < i_geom.chroma_rows);
            last_ty  = i_geom.chroma_last_ty;
            odd_rows = i_geom.chroma_odd;
        end else begin
            in_area  = ({1'b0, i_req.col} < i_geom.width) &&
                       ({1'b0, i_req.row} < i_geom.luma_rows);
            last_ty  = i_geom.luma_last_ty;
            odd_rows = i_geom.luma_odd;
        end

        // zig-zag order over tile row pairs
        pair_base = nv12dt_pkg::POS_W'({ty[nv12dt_pkg::TY_W-1:1], 1'b0} * i_geom.tw_even);
        tx_p2     = (nv12dt_pkg::TWC_W+1)'(tx) + (nv12dt_pkg::TWC_W+1)'(2);
        priority if (ty[0]) begin
            zz_adj = (nv12dt_pkg::TWC_W+1)'({tx[nv12dt_pkg::TX_W-1:2], 2'b00}) +
                     (nv12dt_pkg::TWC_W+1)'(2);
        end else if (!odd_rows || ty != last_ty) begin
            zz_adj = {tx_p2[nv12dt_pkg::TWC_W:2], 2'b00};
        end else begin
            zz_adj = '0;   // unpaired last tile row runs straight
        end
        pos = pair_base + nv12dt_pkg::POS_W'(tx) + nv12dt_pkg::POS_W'(zz_adj);

        // row[4] picks the chroma half tile, and equals the luma row offset split
        src = nv12dt_pkg::OFF_W'({pos, {nv12dt_pkg::TILE_SHIFT{1'b0}}})
            + nv12dt_pkg::OFF_W'({i_req.row[4:0], i_req.col[5:0]});
        if (i_req.req_type == nv12dt_pkg::PLANE_CHROMA) begin
            src = src + i_geom.chroma_base;
        end

        dst = (nv12dt_pkg::OFF_W+1)'(i_req.row * i_geom.line)
            + (nv12dt_pkg::OFF_W+1)'(i_req.col);

        o_res.src_offset = in_area ? src : '0;
        o_res.dst_offset = dst[nv12dt_pkg::OFF_W-1:0];
        o_res.in_frame   = in_area;
    end

endmodule

`default_nettype wire

// ----- design/tiled_nv12_detile_address.sv -----
// an accepted word passes the input and result registers to o_res with o_strobe
// throughput: one word per cycle while busy is low, set by the single
//   mapping stage between the input register and the result register
// the receiver cannot stall, so busy is only high during and right after reset
// reset: synchronous active low; registers return to 1920 x 1080, line 1920,
//   and the pipeline empties; geometry settles in the cycle after any write
// ----------------------------------------------------------------------------
// tiled_nv12_detile_address
// maps nv12 linear byte positions to 64x32 zig-zag tiled source offsets
// ----------------------------------------------------------------------------
`default_nettype none

module tiled_nv12_detile_address (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // command side
    input  wire logic                          start,
    output      logic                          busy,
    input  wire nv12dt_pkg::t_req              i_req,
    // result side
    output      logic                          o_strobe,
    output      nv12dt_pkg::t_res              o_res,
    // configuration write port
    input  wire logic                          i_cfg_we,
    input  wire logic [nv12dt_pkg::IDX_W-1:0]  i_cfg_idx,
    input  wire logic [nv12dt_pkg::CFG_W-1:0]  i_cfg_data
);

    logic               r_busy;
    logic               r_req_vld;
    nv12dt_pkg::t_req   r_req;
    logic               r_res_vld;
    nv12dt_pkg::t_res   r_res;
    nv12dt_pkg::t_res   n_res;
    nv12dt_pkg::t_geom  geom;
    logic               accept;

    // config registers plus registered tile counts and chroma base
    nv12dt_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_geom     (geom)
    );

    // a word is taken whenever start is seen while busy is low
    assign accept = start && !r_busy;

    // busy covers reset and the first cycle after it, giving the
    // geometry register time to load from the reset register values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_req_vld <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            r_busy    <= 1'b0;
            r_req_vld <= accept;
            r_res_vld <= r_req_vld;
        end
    end

    // input register: payload only, valid carried separately
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
    end

    // mapping: tile index multiply, offset adds and line multiply
    nv12dt_map u_map (
        .i_req  (r_req),
        .i_geom (geom),
        .o_res  (n_res)
    );

    // result register, loaded only for a valid word; o_strobe marks it for one cycle
    always_ff @(posedge i_clk) begin
        if (r_req_vld) begin
            r_res <= n_res;
        end
    end

    assign busy     = r_busy;
    assign o_strobe = r_res_vld;
    assign o_res    = r_res;

`ifndef SYNTHESIS
    // every accepted word gives a strobe once through the input and result registers
    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##2 o_strobe)
        else $error("accepted word produced no result");

    // no strobe without an earlier accepted word passed through both registers
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept, 2))
        else $error("result strobe without accepted word");

    // positions outside the copied area carry a zero source offset
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_res.in_frame) |-> (o_res.src_offset == '0))
        else $error("source offset set outside the frame");

    // busy drops in the cycle after reset ends and stays low
    a_busy_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !busy)
        else $error("busy raised outside reset");
`endif

endmodule

`default_nettype wire

// ----- verif/tiled_nv12_detile_address_tb.sv -----
// ----------------------------------------------------------------------------
// tiled_nv12_detile_address_tb
// self-checking bench for the nv12 64x32 zig-zag detile address block: an
// internal address model predicts source offset, destination offset and the
// in-frame flag for every word, across many frame geometries and sender gaps
// ----------------------------------------------------------------------------
module tiled_nv12_detile_address_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // index with no register behind it, writes must be ignored
    localparam logic [nv12dt_pkg::IDX_W-1:0] REG_UNMAPPED = 2'd3;

    localparam int unsigned TILE_BYTES  = 1 << nv12dt_pkg::TILE_SHIFT;
    localparam int unsigned HALF_TILE   = TILE_BYTES / 2;
    localparam int unsigned GROUP_BYTES = 1 << nv12dt_pkg::GROUP_SHIFT;
    localparam int unsigned MAX_COORD   = (1 << nv12dt_pkg::ROW_W) - 1;

    logic                         i_clk      = 1'b0;
    logic                         i_rst_n    = 1'b0;
    logic                         start      = 1'b0;
    logic                         busy;
    nv12dt_pkg::t_req             i_req      = '0;
    logic                         o_strobe;
    nv12dt_pkg::t_res             o_res;
    logic                         i_cfg_we   = 1'b0;
    logic [nv12dt_pkg::IDX_W-1:0] i_cfg_idx  = '0;
    logic [nv12dt_pkg::CFG_W-1:0] i_cfg_data = '0;

    // shadow copy of the register file, updated as the writes land
    logic [nv12dt_pkg::WIDTH_W-1:0] frame_w_reg = nv12dt_pkg::RST_FRAME_WIDTH;
    logic [nv12dt_pkg::WIDTH_W-1:0] frame_h_reg = nv12dt_pkg::RST_FRAME_HEIGHT;
    logic [nv12dt_pkg::LINE_W-1:0]  line_reg    = nv12dt_pkg::RST_LINE_SIZE;

    // predicted result words, oldest first
    nv12dt_pkg::t_res pending_offsets[$];
    int unsigned      idle_pct = 6;
    int unsigned      words_sent;
    int unsigned      words_checked;
    int unsigned      frames_used;
    int unsigned      error_count;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    tiled_nv12_detile_address i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_strobe   (o_strobe),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // address model
    // ------------------------------------------------------------------------

    function automatic int unsigned clip(input int unsigned v, input int unsigned lim);
        return (v > lim) ? lim : v;
    endfunction

    // tile index inside a pair of tile rows laid out in zig-zag groups of four;
    // the last tile row of an odd count is stored linearly
    function automatic int unsigned zigzag_tile(input int unsigned tx, input int unsigned ty,
                                                input int unsigned row_tiles,
                                                input int unsigned tile_rows);
        int unsigned idx;
        idx = tx + (ty & ~32'd1) * row_tiles;
        if ((ty & 32'd1) != 0)
            idx += (tx & ~32'd3) + 2;
        else if ((tile_rows & 32'd1) == 0 || ty != tile_rows - 1)
            idx += (tx + 2) & ~32'd3;
        return idx;
    endfunction

    // rows of the selected plane that are copied
    function automatic int unsigned plane_rows(input logic plane);
        int unsigned h;
        h = clip(frame_h_reg, nv12dt_pkg::MAX_HEIGHT);
        // an odd last luma row is dropped, chroma has half the rows
        return (plane == nv12dt_pkg::PLANE_CHROMA) ? h / 2 : h & ~32'd1;
    endfunction

    function automatic nv12dt_pkg::t_res map_position(input nv12dt_pkg::t_req req);
        int unsigned      w, h, ls, rows, tw_even, th_luma, th_chroma;
        int unsigned      tx, cx, lty, luma_bytes, src, dst;
        logic             in_area;
        nv12dt_pkg::t_res res;
        w    = clip(frame_w_reg, nv12dt_pkg::MAX_WIDTH);
        h    = clip(frame_h_reg, nv12dt_pkg::MAX_HEIGHT);
        ls   = clip(line_reg, nv12dt_pkg::MAX_LINE_SIZE);
        rows = plane_rows(req.req_type);
        in_area = (req.col < w) && (req.row < rows);
        src = 0;
        if (in_area) begin
            // tile row width rounded up to an even tile count
            tw_even = ((w - 1) / nv12dt_pkg::TILE_W + 2) & ~32'd1;
            th_luma = (h - 1) / nv12dt_pkg::TILE_H + 1;
            tx = req.col / nv12dt_pkg::TILE_W;
            cx = req.col % nv12dt_pkg::TILE_W;
            if (req.req_type == nv12dt_pkg::PLANE_LUMA) begin
                src = zigzag_tile(tx, req.row / nv12dt_pkg::TILE_H, tw_even, th_luma)
                    * TILE_BYTES
                    + (req.row % nv12dt_pkg::TILE_H) * nv12dt_pkg::TILE_W + cx;
            end else begin
                // chroma plane starts after the luma plane rounded to a group
                th_chroma  = (h / 2 - 1) / nv12dt_pkg::TILE_H + 1;
                luma_bytes = tw_even * th_luma * TILE_BYTES;
                luma_bytes = (luma_bytes + GROUP_BYTES - 1) / GROUP_BYTES * GROUP_BYTES;
                // each 16-row chroma band fills one half of a chroma tile
                lty = req.row / (nv12dt_pkg::TILE_H / 2);
                src = luma_bytes
                    + zigzag_tile(tx, lty / 2, tw_even, th_chroma) * TILE_BYTES
                    + (lty % 2) * HALF_TILE
                    + (req.row % (nv12dt_pkg::TILE_H / 2)) * nv12dt_pkg::TILE_W + cx;
            end
        end
        dst = req.row * ls + req.col;
        res.src_offset = src[nv12dt_pkg::OFF_W-1:0];
        res.dst_offset = dst[nv12dt_pkg::OFF_W-1:0];
        res.in_frame   = in_area;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    function automatic nv12dt_pkg::t_req byte_pos(input logic plane, input int unsigned row,
                                                  input int unsigned col);
        nv12dt_pkg::t_req req;
        req.req_type = plane;
        req.row      = nv12dt_pkg::ROW_W'(row);
        req.col      = nv12dt_pkg::COL_W'(col);
        return req;
    endfunction

    // mostly positions inside the copied area, some straddling its edges,
    // the rest anywhere in the 12-bit range
    function automatic nv12dt_pkg::t_req random_word();
        nv12dt_pkg::t_req req;
        int unsigned      w, rows, pick;
        req.req_type = 1'($urandom_range(1));
        req.row      = nv12dt_pkg::ROW_W'($urandom);
        req.col      = nv12dt_pkg::COL_W'($urandom);
        w    = clip(frame_w_reg, nv12dt_pkg::MAX_WIDTH);
        rows = plane_rows(req.req_type);
        pick = $urandom_range(99);
        if (pick < 75 && w != 0 && rows != 0) begin
            req.row = nv12dt_pkg::ROW_W'($urandom_range(rows - 1));
            req.col = nv12dt_pkg::COL_W'($urandom_range(w - 1));
        end else if (pick < 90) begin
            req.row = nv12dt_pkg::ROW_W'(clip((rows == 0) ? $urandom_range(1)
                                              : rows - 1 + $urandom_range(1), MAX_COORD));
            req.col = nv12dt_pkg::COL_W'(clip((w == 0) ? $urandom_range(1)
                                              : w - 1 + $urandom_range(1), MAX_COORD));
        end
        return req;
    endfunction

    // one word through the start/busy handshake, with random sender gaps;
    // the address lines carry noise while start is low
    task automatic send_word(input nv12dt_pkg::t_req req);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            i_req <= nv12dt_pkg::t_req'($urandom);
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= req;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        pending_offsets.push_back(map_position(req));
        words_sent++;
    endtask

    task automatic send_random(input int unsigned count);
        repeat (count)
            send_word(random_word());
    endtask

    // every word issued has its result back, and the pipeline has emptied
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_offsets.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // leaves the write enable high, the caller drops it after the last write
    task automatic write_reg(input logic [nv12dt_pkg::IDX_W-1:0] idx,
                             input logic [nv12dt_pkg::CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        unique case (idx)
            nv12dt_pkg::REG_FRAME_WIDTH:  frame_w_reg = data[nv12dt_pkg::WIDTH_W-1:0];
            nv12dt_pkg::REG_FRAME_HEIGHT: frame_h_reg = data[nv12dt_pkg::WIDTH_W-1:0];
            nv12dt_pkg::REG_LINE_SIZE:    line_reg    = data[nv12dt_pkg::LINE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_frame(input int unsigned w, input int unsigned h, input int unsigned ls);
        wait_idle();
        write_reg(nv12dt_pkg::REG_FRAME_WIDTH, nv12dt_pkg::CFG_W'(w));
        write_reg(nv12dt_pkg::REG_FRAME_HEIGHT, nv12dt_pkg::CFG_W'(h));
        write_reg(nv12dt_pkg::REG_LINE_SIZE, nv12dt_pkg::CFG_W'(ls));
        i_cfg_we <= 1'b0;
        // geometry is derived and registered in the cycle after the last write lands
        repeat (2) @(posedge i_clk);
        frames_used++;
    endtask

    // ------------------------------------------------------------------------
    // result checker: the receiver never stalls, so a strobe is a result
    // ------------------------------------------------------------------------

    always @(posedge i_clk) begin : check_offsets
        nv12dt_pkg::t_res want;
        if (i_rst_n && o_strobe) begin
            if (pending_offsets.size() == 0) begin
                $display("%0t: result word with none expected, got %h", $time, o_res);
                error_count++;
            end else begin
                want = pending_offsets.pop_front();
                words_checked++;
                if (o_res.src_offset !== want.src_offset) begin
                    $display("%0t: src_offset expected %h got %h",
                             $time, want.src_offset, o_res.src_offset);
                    error_count++;
                end
                if (o_res.dst_offset !== want.dst_offset) begin
                    $display("%0t: dst_offset expected %h got %h",
                             $time, want.dst_offset, o_res.dst_offset);
                    error_count++;
                end
                if (o_res.in_frame !== want.in_frame) begin
                    $display("%0t: in_frame expected %b got %b",
                             $time, want.in_frame, o_res.in_frame);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset geometry 1920 x 1080, line 1920: frame edges, tile and group
    // corners of the zig-zag order, chroma halves and full-range coordinates
    task automatic test_reset_edges();
        send_word(byte_pos(nv12dt_pkg::PLANE_LUMA, 0, 0));
        send_word(byte_pos(nv12dt_pkg::PLANE_LUMA, 0, 1919));
        send_word(byte_pos(nv12dt_pkg::PLANE_LUMA, 0, 1920));
        send_word(byte_pos(nv12dt_pkg::PLANE_LUMA, 1079, 1919));
        send_word(byte_pos(nv12dt_pkg::PLANE_LUMA, 1080, 0));
        send_word(byte_pos(nv12dt_pkg::PLANE_LUMA, 31, 63));
        send_word(byte_pos(nv12dt_pkg::PLANE_LUMA, 32, 64));
        send_word(byte_pos(nv12dt_pkg::PLANE_LUMA, 33, 128));
        send_word(byte_pos(nv12dt_pkg::PLANE_LUMA, 5, 192));
        send_word(byte_pos(nv12dt_pkg::PLANE_LUMA, 40, 255));
        send_word(byte_pos(nv12dt_pkg::PLANE_LUMA, 1, 1));
        send_word(byte_pos(nv12dt_pkg::PLANE_CHROMA, 0, 0));
        send_word(byte_pos(nv12dt_pkg::PLANE_CHROMA, 15, 63));
        send_word(byte_pos(nv12dt_pkg::PLANE_CHROMA, 16, 64));
        send_word(byte_pos(nv12dt_pkg::PLANE_CHROMA, 31, 128));
        send_word(byte_pos(nv12dt_pkg::PLANE_CHROMA, 32, 200));
        send_word(byte_pos(nv12dt_pkg::PLANE_CHROMA, 539, 1919));
        send_word(byte_pos(nv12dt_pkg::PLANE_CHROMA, 540, 0));
        send_word(byte_pos(nv12dt_pkg::PLANE_CHROMA, 1, 1));
        send_word(byte_pos(nv12dt_pkg::PLANE_LUMA, MAX_COORD, MAX_COORD));
        send_word(byte_pos(nv12dt_pkg::PLANE_CHROMA, MAX_COORD, MAX_COORD));
        send_word(byte_pos(nv12dt_pkg::PLANE_LUMA, 12'hAAA, 12'h555));
        send_word(byte_pos(nv12dt_pkg::PLANE_CHROMA, 12'h555, 12'hAAA));
    endtask

    // tiny frames, odd heights and partial tiles
    task automatic test_small_frames();
        set_frame(1, 1, 1);          // no luma row and no chroma row copied
        send_random(20);
        set_frame(1, 2, 1);
        send_random(20);
        set_frame(64, 32, 64);       // exactly one tile
        send_random(40);
        set_frame(65, 33, 100);      // one byte into the next tiles
        send_random(40);
        set_frame(100, 3, 100);      // odd last luma row dropped
        send_random(20);
    endtask

    // odd tile row counts take the linear path on the last tile row
    task automatic test_odd_tile_rows();
        set_frame(200, 96, 256);     // three luma tile rows
        send_random(40);
        set_frame(130, 64, 130);     // one chroma tile row, tile width rounded up
        send_random(40);
        set_frame(300, 192, 320);    // six luma, three chroma tile rows
        send_random(40);
    endtask

    task automatic test_max_frame();
        set_frame(nv12dt_pkg::MAX_WIDTH, nv12dt_pkg::MAX_HEIGHT, nv12dt_pkg::MAX_LINE_SIZE);
        send_random(80);
        send_word(byte_pos(nv12dt_pkg::PLANE_LUMA, MAX_COORD, MAX_COORD));
        send_word(byte_pos(nv12dt_pkg::PLANE_CHROMA, 2047, MAX_COORD));
        send_word(byte_pos(nv12dt_pkg::PLANE_CHROMA, 2048, 0));
        set_frame(4095, 4095, 4096);
        send_random(40);
    endtask

    // oversized values saturate, bits above a register's width are dropped,
    // and the unmapped index changes nothing
    task automatic test_saturation();
        set_frame(8191, 8191, 16383);
        send_random(40);
        set_frame(14'h3FFF, 14'h2040, 14'h3FFF);   // height keeps only 64
        send_random(30);
        wait_idle();
        write_reg(REG_UNMAPPED, '1);
        i_cfg_we <= 1'b0;
        repeat (2) @(posedge i_clk);
        send_random(30);
    endtask

    task automatic test_zero_registers();
        set_frame(0, 1080, 1920);
        send_random(20);
        set_frame(1920, 0, 1920);
        send_random(20);
        set_frame(640, 480, 0);      // destination offset is just the column
        send_random(40);
    endtask

    // destination lines shorter than the frame, offsets may coincide
    task automatic test_narrow_line();
        set_frame(1000, 700, 100);
        send_random(60);
        set_frame(nv12dt_pkg::MAX_WIDTH, nv12dt_pkg::MAX_HEIGHT, 1);
        send_random(40);
    endtask

    task automatic test_random_frames();
        int unsigned w, h;
        repeat (6) begin
            w = $urandom_range(1, nv12dt_pkg::MAX_WIDTH);
            h = $urandom_range(1, nv12dt_pkg::MAX_HEIGHT);
            set_frame(w, h, ($urandom_range(4) == 0) ? $urandom_range(1, 16383) : w);
            send_random(50);
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sender rarely idles
        idle_pct = 6;
        test_reset_edges();
        test_small_frames();
        test_odd_tile_rows();

        // sender mostly idle
        idle_pct = 80;
        test_max_frame();
        test_saturation();
        test_zero_registers();
        test_narrow_line();

        // back to back words
        idle_pct = 0;
        test_random_frames();

        wait_idle();
        $display("run covered %0d words over %0d frame settings plus reset geometry",
                 words_sent, frames_used);
        $display("%0d result words checked, %0d mismatches", words_checked, error_count);
        if (error_count == 0 && words_checked == words_sent)
            $display("tiled_nv12_detile_address verification clean");
        else
            $display("tiled_nv12_detile_address verification failed");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("timeout with %0d words outstanding", pending_offsets.size());
        $display("tiled_nv12_detile_address verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
design/nv12dt_pkg.sv
design/nv12dt_cfg.sv
design/nv12dt_map.sv
design/tiled_nv12_detile_address.sv
verif/tiled_nv12_detile_address_tb.sv
